// ===== src/itaf_pkg.sv =====
package itaf_pkg;

  localparam int ITAF_VALUE_W    = 64;
  localparam int ITAF_PAD_W      = 5;
  localparam int ITAF_DEC_DIGITS = 20;
  localparam int ITAF_HEX_DIGITS = 16;
  localparam int ITAF_DIGITS_W   = 4 * ITAF_DEC_DIGITS;
  localparam int ITAF_IDX_W      = 5;
  localparam int ITAF_JOB_DEPTH  = 2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UPPER = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_X     = 8'h78;

  typedef struct packed {
    logic                    cmd;
    logic [ITAF_VALUE_W-1:0] value;
    logic [ITAF_PAD_W-1:0]   pad_digits;
  } itaf_in_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } itaf_out_t;

  // One classified item: digit nibbles, least significant first.
  typedef struct packed {
    logic                     is_hex;
    logic                     neg;
    logic [ITAF_PAD_W-1:0]    pad;
    logic [ITAF_DIGITS_W-1:0] digits;
  } itaf_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } itaf_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEAD,
    B_X,
    B_DIGIT
  } itaf_back_state_t;

endpackage

// ===== src/itaf_front.sv =====
module itaf_front
  import itaf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  itaf_in_t  in_data,
  output logic      q_push,
  input  logic      q_full,
  output itaf_job_t q_data
);

  localparam int CONV_STEPS = ITAF_VALUE_W / 2;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int SHIFT_W    = ITAF_DIGITS_W + ITAF_VALUE_W;
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_STEPS - 1);

  // Two double-dabble steps: correct each BCD digit, then shift in one bit.
  function automatic logic [SHIFT_W-1:0] dabble2(input logic [SHIFT_W-1:0] v);
    logic [SHIFT_W-1:0] t;
    logic [3:0]         d;
    t = v;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < ITAF_DEC_DIGITS; k++) begin
        d = t[ITAF_VALUE_W + 4*k +: 4];
        if (d >= 4'd5) begin
          t[ITAF_VALUE_W + 4*k +: 4] = d + 4'd3;
        end
      end
      t = {t[SHIFT_W-2:0], 1'b0};
    end
    return t;
  endfunction

  itaf_front_state_t       state_r, state_nxt;
  itaf_job_t               job_r;
  logic [ITAF_VALUE_W-1:0] bin_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    accept;
  logic                    neg;
  logic [ITAF_VALUE_W-1:0] mag;
  logic [SHIFT_W-1:0]      dab;

  assign accept = in_push && !in_full;
  assign neg    = !in_data.cmd && in_data.value[ITAF_VALUE_W-1];
  assign mag    = neg ? (~in_data.value + ITAF_VALUE_W'(1)) : in_data.value;
  assign dab    = dabble2({job_r.digits, bin_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = in_data.cmd ? F_PUSH : F_CONV;
      F_CONV: if (cnt_r == CONV_LAST) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full = (state_r != F_IDLE);
    q_push  = (state_r == F_PUSH) && !q_full;
    q_data  = job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == F_CONV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.is_hex <= in_data.cmd;
      job_r.neg    <= neg;
      job_r.pad    <= in_data.pad_digits;
      if (in_data.cmd) begin
        job_r.digits <= {{(ITAF_DIGITS_W - ITAF_VALUE_W){1'b0}}, in_data.value};
      end else begin
        job_r.digits <= '0;
      end
      bin_r <= mag;
    end else if (state_r == F_CONV) begin
      {job_r.digits, bin_r} <= dab;
    end
  end

endmodule

// ===== src/itaf_jobq.sv =====
module itaf_jobq
  import itaf_pkg::*;
#(
  parameter int DEPTH = ITAF_JOB_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  output logic      q_full,
  input  itaf_job_t q_wdata,
  input  logic      q_pop,
  output logic      q_empty,
  output itaf_job_t q_rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  itaf_job_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign q_full  = (count_r == CNT_FULL);
  assign q_empty = (count_r == '0);
  assign q_rdata = mem[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/itaf_back.sv =====
module itaf_back
  import itaf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  itaf_job_t q_rdata,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output itaf_out_t out_data
);

  localparam logic [ITAF_IDX_W-1:0] DEC_TOP = ITAF_IDX_W'(ITAF_DEC_DIGITS - 1);
  localparam logic [ITAF_IDX_W-1:0] HEX_TOP = ITAF_IDX_W'(ITAF_HEX_DIGITS - 1);

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic is_hex);
    logic [7:0] c;
    if (is_hex && d >= 4'd10) begin
      c = ASCII_UPPER + {4'd0, d} - 8'd10;
    end else begin
      c = ASCII_ZERO + {4'd0, d};
    end
    return c;
  endfunction

  itaf_back_state_t      state_r, state_nxt;
  itaf_job_t             job_r;
  logic [ITAF_IDX_W-1:0] idx_r;
  logic                  seen_r;
  logic                  slot_valid_r;
  itaf_out_t             slot_r;

  logic                  slot_free;
  logic [3:0]            dig;
  logic                  skip;
  logic                  emit;
  itaf_out_t             emit_data;

  assign slot_free = !slot_valid_r || out_pop;
  assign dig       = job_r.digits[{idx_r, 2'b00} +: 4];
  // Drop leading zeros until the first real digit; for hex, only those above the pad width.
  assign skip = !seen_r && (idx_r != '0) && (dig == 4'd0) &&
                (!job_r.is_hex || idx_r >= job_r.pad);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_rdata.is_hex || q_rdata.neg) ? B_LEAD : B_DIGIT;
        end
      end
      B_LEAD: begin
        if (slot_free) state_nxt = job_r.is_hex ? B_X : B_DIGIT;
      end
      B_X: begin
        if (slot_free) state_nxt = B_DIGIT;
      end
      B_DIGIT: begin
        if (!skip && slot_free && idx_r == '0) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_r)
      B_IDLE: q_pop = !q_empty;
      B_LEAD: begin
        emit                 = slot_free;
        emit_data.ascii_char = job_r.is_hex ? ASCII_ZERO : ASCII_MINUS;
      end
      B_X: begin
        emit                 = slot_free;
        emit_data.ascii_char = ASCII_X;
      end
      B_DIGIT: begin
        emit                 = !skip && slot_free;
        emit_data.ascii_char = digit_char(dig, job_r.is_hex);
        emit_data.last       = (idx_r == '0);
      end
      default: ;
    endcase
  end

  assign out_empty = !slot_valid_r;
  assign out_data  = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      slot_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        slot_valid_r <= 1'b1;
      end else if (out_pop) begin
        slot_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot_r <= emit_data;
    end
    if (state_r == B_IDLE) begin
      job_r  <= q_rdata;
      idx_r  <= q_rdata.is_hex ? HEX_TOP : DEC_TOP;
      seen_r <= 1'b0;
    end else if (state_r == B_DIGIT) begin
      if (skip) begin
        idx_r <= idx_r - ITAF_IDX_W'(1);
      end else if (slot_free) begin
        seen_r <= 1'b1;
        if (idx_r != '0) begin
          idx_r <= idx_r - ITAF_IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/integer_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter.
// Input channel: push an item (cmd, value, pad_digits) while in_full is low.
// cmd 0 prints value as signed decimal, cmd 1 prints "0x" and uppercase hex
// zero-padded to pad_digits digits (at least one digit, at most sixteen).
// Result channel: one character per beat; the character on out_data is valid
// while out_empty is low and is taken with out_pop. last marks the final
// character of an item.
// The front end converts and queues items; the back end prints them, so a new
// item can be taken while earlier characters are still being drained.
// Decimal items go through the front end's binary-to-BCD shift loop (two bits
// per cycle); for any item, the front end takes no new item until the current
// one has been pushed to the queue. The back end takes an item from the queue,
// emits the "-" or "0x" prefix if any, drops leading zero digit positions,
// then emits the digits; it takes the next item only after the last character
// of the current one.
// When the receiver stalls, the output register holds its character, the back
// end stops, the job queue fills, and then in_full rises.
// Reset clears the control state; no item or character is pending after it.
module integer_to_ascii_formatter_unit
  import itaf_pkg::*;
#(
  parameter int JOB_DEPTH = ITAF_JOB_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  itaf_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output itaf_out_t out_data
);

  logic      fq_push, fq_full, bq_pop, bq_empty;
  itaf_job_t fq_data, bq_data;

  itaf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_data  (fq_data)
  );

  itaf_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_wdata (fq_data),
    .q_pop   (bq_pop),
    .q_empty (bq_empty),
    .q_rdata (bq_data)
  );

  itaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (bq_empty),
    .q_rdata   (bq_data),
    .q_pop     (bq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_integer_to_ascii_formatter_unit.sv =====
module tb_integer_to_ascii_formatter_unit
  import itaf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  // Expected characters for every accepted item, oldest first.
  class formatted_char_board;
    itaf_out_t pending_chars[$];
    int        errors;
    int        chars_checked;
    int        dec_items;
    int        hex_items;

    function void note_item(itaf_in_t item);
      logic [63:0] mag;
      logic [3:0]  nib[20];
      logic [3:0]  d;
      logic [7:0]  line[$];
      int          cnt;
      int          width;
      int          total;
      int          i;
      itaf_out_t   c;
      cnt = 0;
      if (item.cmd == CMD_DEC) begin
        dec_items++;
        mag = item.value[63] ? (~item.value + 64'd1) : item.value;
        do begin
          nib[cnt] = 4'(mag % 64'd10);
          mag = mag / 64'd10;
          cnt++;
        end while (mag != 64'd0);
        if (item.value[63]) line.push_back(ASCII_MINUS);
        for (i = cnt - 1; i >= 0; i--) line.push_back(ASCII_ZERO + 8'(nib[i]));
      end else begin
        hex_items++;
        width = (item.pad_digits > 5'd16) ? 16 : int'(item.pad_digits);
        mag = item.value;
        do begin
          nib[cnt] = mag[3:0];
          mag = mag >> 4;
          cnt++;
        end while (mag != 64'd0);
        line.push_back(ASCII_ZERO);
        line.push_back(ASCII_X);
        total = (width > cnt) ? width : cnt;
        for (i = total - 1; i >= 0; i--) begin
          d = (i < cnt) ? nib[i] : 4'd0;
          line.push_back((d < 4'd10) ? ASCII_ZERO + 8'(d) : ASCII_UPPER + 8'(d - 4'd10));
        end
      end
      for (i = 0; i < line.size(); i++) begin
        c.ascii_char = line[i];
        c.last       = (i == line.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(itaf_out_t got);
      itaf_out_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, nothing pending: char 0x%02h last %0b",
                 $time, got.ascii_char, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.ascii_char !== want.ascii_char) begin
        $display("%0t: ascii_char mismatch: expected 0x%02h, actual 0x%02h",
                 $time, want.ascii_char, got.ascii_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  itaf_in_t  in_data;
  logic      out_empty;
  logic      out_pop;
  itaf_out_t out_data;

  formatted_char_board board = new();

  int tx_idle_max = 15;
  int rx_idle_max = 15;
  int rx_hold_req = 0;
  int full_stall_cycles = 0;
  int items_sent = 0;

  integer_to_ascii_formatter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic itaf_in_t make_item(logic c, logic [63:0] v, logic [4:0] p);
    itaf_in_t item;
    item.cmd        = c;
    item.value      = v;
    item.pad_digits = p;
    return item;
  endfunction

  function automatic itaf_in_t rand_item();
    logic [63:0] v;
    logic [4:0]  p;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'd0 - 64'($urandom_range(1, 100000));
      3: v = 64'($urandom_range(0, 1000));
      // around the most negative and the most positive value
      default: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 20)) - 64'd10;
    endcase
    p = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                     : 5'($urandom_range(0, 16));
    return make_item($urandom_range(0, 1) ? CMD_HEX : CMD_DEC, v, p);
  endfunction

  task automatic push_item(input itaf_in_t item);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    // hold until the beat is taken
    do begin
      @(posedge clk);
      if (in_full) full_stall_cycles++;
    end while (in_full);
    board.note_item(item);
    items_sent++;
  endtask

  task automatic drain_all();
    in_push <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int hold;
    out_pop = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold = $urandom_range(0, rx_idle_max);
      end
      if (hold > 0) begin
        out_pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      board.check_char(out_data);
    end
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    itaf_in_t directed[$];
    int i;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_item(CMD_DEC, 64'd0, 5'd0));
    directed.push_back(make_item(CMD_DEC, 64'd1, 5'd31));
    directed.push_back(make_item(CMD_DEC, 64'd9, 5'd16));
    directed.push_back(make_item(CMD_DEC, 64'd10, 5'd1));
    directed.push_back(make_item(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0));
    directed.push_back(make_item(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFF6, 5'd5));
    directed.push_back(make_item(CMD_DEC, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0));
    directed.push_back(make_item(CMD_DEC, 64'h8000_0000_0000_0000, 5'd0));
    directed.push_back(make_item(CMD_DEC, 64'h8000_0000_0000_0001, 5'd20));
    directed.push_back(make_item(CMD_DEC, 64'd1000000000000000000, 5'd0));
    directed.push_back(make_item(CMD_HEX, 64'd0, 5'd0));
    directed.push_back(make_item(CMD_HEX, 64'd0, 5'd1));
    directed.push_back(make_item(CMD_HEX, 64'd0, 5'd16));
    directed.push_back(make_item(CMD_HEX, 64'd0, 5'd17));
    directed.push_back(make_item(CMD_HEX, 64'd0, 5'd31));
    directed.push_back(make_item(CMD_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0));
    directed.push_back(make_item(CMD_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16));
    directed.push_back(make_item(CMD_HEX, 64'h0000_0000_00AB_CDEF, 5'd10));
    directed.push_back(make_item(CMD_HEX, 64'd1, 5'd2));
    directed.push_back(make_item(CMD_HEX, 64'h8000_0000_0000_0000, 5'd3));
    directed.push_back(make_item(CMD_HEX, 64'h0123_4567_89AB_CDEF, 5'd20));
    directed.push_back(make_item(CMD_HEX, 64'hF, 5'd0));
    foreach (directed[k]) push_item(directed[k]);

    for (i = 0; i < 70; i++) push_item(rand_item());

    // hold the result side while items keep coming, so in_full rises
    drain_all();
    tx_idle_max = 0;
    rx_hold_req = 800;
    for (i = 0; i < 30; i++) push_item(rand_item());

    // pause until every pending character has come out
    drain_all();
    tx_idle_max = 0;
    rx_idle_max = 0;
    for (i = 0; i < 60; i++) push_item(rand_item());

    tx_idle_max = 15;
    rx_idle_max = 15;
    for (i = 0; i < 70; i++) push_item(rand_item());

    tx_idle_max = 0;
    rx_idle_max = 3;
    for (i = 0; i < 20; i++) push_item(rand_item());
    in_push <= 1'b0;

    drain_all();
    repeat (60) @(posedge clk);

    $display("Formatted %0d items (%0d decimal, %0d hex), checked %0d characters,",
             items_sent, board.dec_items, board.hex_items, board.chars_checked);
    $display("input held off by full for %0d cycles, %0d mismatches.",
             full_stall_cycles, board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/itaf_pkg.sv
src/itaf_front.sv
src/itaf_jobq.sv
src/itaf_back.sv
src/integer_to_ascii_formatter_unit.sv
tb/tb_integer_to_ascii_formatter_unit.sv
